// ===== sv/upd_pkg.sv =====
// shared types and constants of the url percent decoder
`timescale 1ns / 1ps

package upd_pkg;

    localparam int CAP_W                = 13;
    localparam int LEN_W                = 12;
    localparam int MAX_CAPACITY_DEFAULT = 4096;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF  = 8'h66;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;
    localparam logic [3:0] NIB_TEN = 4'd10;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_PCT   = 2'd1,
        MODE_HI    = 2'd2,
        MODE_DROP  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_BADHEX   = 3'd3,
        ST_ZERO     = 3'd4
    } status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic       is_end;
        logic       is_pct;
        logic       hex_ok;
        logic [3:0] nibble;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        status_t          status;
        logic [LEN_W-1:0] length;
    } result_t;

endpackage

// ===== sv/url_percent_decoder.sv =====
// top level of the url percent decoder
`timescale 1ns / 1ps

// usage:
// input side is a queue write port: an encoded character (in_byte) or an end
// item (end_marker high) transfers at a clock edge with push high and full low.
// result side is a queue read port: while empty is low the oldest result is on
// result_kind, data_byte, status and out_length; it transfers when pop is high.
// a plain character or a completed escape gives a data result, the end item
// gives a final status with the string length; after one overflow, bad hex or
// zero status, items are dropped through the next end item, which gives none.
// an item is written into the item queue; the escape state machine takes it
// from there and writes its result into the result queue, where it waits to
// be read. throughput: 1 item per cycle while the result queue is not full,
// set by the escape state machine; each 2 entry queue keeps full rates with
// one transfer per cycle on each side. capacity is written through cfg_we /
// cfg_wdata; the user must write it only while the block is idle, which the
// block does not enforce. reset empties both queues, returns to plain text and
// sets capacity to 4096. when the receiver stalls the result queue fills, the
// state machine halts, the item queue fills and full rises; nothing is lost.

module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int MAX_CAPACITY = MAX_CAPACITY_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       in_byte,
    input  logic             end_marker,
    input  logic             pop,
    output logic             empty,
    output logic             result_kind,
    output logic [7:0]       data_byte,
    output logic [2:0]       status,
    output logic [LEN_W-1:0] out_length,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    logic [CAP_W-1:0] capacity_reg;
    logic             item_empty;
    logic             item_pop;
    item_t            item;
    result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    upd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .end_marker (end_marker),
        .item_pop   (item_pop),
        .item_empty (item_empty),
        .item       (item)
    );

    upd_back #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (capacity_reg),
        .item_empty (item_empty),
        .item       (item),
        .item_pop   (item_pop),
        .pop        (pop),
        .empty      (empty),
        .res        (res)
    );

    assign result_kind = res.kind;
    assign data_byte   = res.data;
    assign status      = res.status;
    assign out_length  = res.length;

endmodule

// ===== sv/upd_fifo.sv =====
// small register queue with count based full and empty
`timescale 1ns / 1ps

module upd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/upd_front.sv =====
// front end: classifies incoming characters and queues them for the decoder
`timescale 1ns / 1ps

module upd_front
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_marker,
    input  logic       item_pop,
    output logic       item_empty,
    output item_t      item
);

    item_t cls;
    logic  is_dig, is_low, is_up;

    always_comb
    begin
        is_dig = (in_byte >= CH_0)  && (in_byte <= CH_9);
        is_low = (in_byte >= CH_LA) && (in_byte <= CH_LF);
        is_up  = (in_byte >= CH_UA) && (in_byte <= CH_UF);
        cls.is_end = end_marker;
        cls.is_pct = (in_byte == CH_PCT);
        cls.hex_ok = is_dig || is_low || is_up;
        cls.ch     = in_byte;
        priority if (is_dig)
        begin
            cls.nibble = in_byte[3:0];
        end
        else if (is_low)
        begin
            cls.nibble = 4'(in_byte - CH_LA) + NIB_TEN;
        end
        else if (is_up)
        begin
            cls.nibble = 4'(in_byte - CH_UA) + NIB_TEN;
        end
        else
        begin
            cls.nibble = '0;
        end
    end

    upd_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .rd_en   (item_pop),
        .rd_data (item),
        .empty   (item_empty)
    );

endmodule

// ===== sv/upd_back.sv =====
// back end: escape state machine, length count and result queue
`timescale 1ns / 1ps

module upd_back
    import upd_pkg::*;
#(
    parameter int MAX_CAPACITY = MAX_CAPACITY_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CAP_W-1:0] capacity,
    input  logic             item_empty,
    input  item_t            item,
    output logic             item_pop,
    input  logic             pop,
    output logic             empty,
    output result_t          res
);

    localparam int MAX_W = $clog2(MAX_CAPACITY + 1);
    localparam int CMP_W = ((MAX_W > CAP_W) ? MAX_W : CAP_W) + 1;

    mode_t            mode_reg, mode_next;
    logic [3:0]       hi_nib_reg, hi_nib_next;
    logic             hi_inv_reg, hi_inv_next;
    logic [LEN_W-1:0] count_reg, count_next;

    logic             res_full;
    logic             advance;
    logic             res_valid;
    result_t          res_new;
    logic [CMP_W-1:0] cap_ext, max_ext, eff_cap, need;
    logic [7:0]       dec_byte;

    assign advance  = !item_empty && !res_full;
    assign item_pop = advance;
    assign cap_ext  = CMP_W'(capacity);
    assign max_ext  = CMP_W'(MAX_CAPACITY);
    assign eff_cap  = (cap_ext > max_ext) ? max_ext : cap_ext;
    assign need     = CMP_W'(count_reg) + CMP_W'(1);
    assign dec_byte = {hi_nib_reg, item.nibble};

    always_comb
    begin
        mode_next      = mode_reg;
        hi_nib_next    = hi_nib_reg;
        hi_inv_next    = hi_inv_reg;
        count_next     = count_reg;
        res_valid      = 1'b0;
        res_new.kind   = KIND_STATUS;
        res_new.data   = '0;
        res_new.status = ST_OK;
        res_new.length = count_reg;
        if (advance)
        begin
            unique case (mode_reg)
                MODE_DROP:
                begin
                    if (item.is_end)
                    begin
                        mode_next  = MODE_PLAIN;
                        count_next = '0;
                    end
                end
                MODE_PLAIN:
                begin
                    if (item.is_end)
                    begin
                        res_valid  = 1'b1;
                        count_next = '0;
                    end
                    else if (need >= eff_cap)
                    begin
                        res_valid      = 1'b1;
                        res_new.status = ST_OVERFLOW;
                        mode_next      = MODE_DROP;
                        hi_nib_next    = '0;
                        hi_inv_next    = 1'b0;
                    end
                    else if (item.is_pct)
                    begin
                        mode_next = MODE_PCT;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        res_new.kind   = KIND_DATA;
                        res_new.data   = item.ch;
                        res_new.length = count_reg + LEN_W'(1);
                        count_next     = count_reg + LEN_W'(1);
                    end
                end
                MODE_PCT:
                begin
                    if (item.is_end)
                    begin
                        res_valid      = 1'b1;
                        res_new.status = ST_TRUNC;
                        mode_next      = MODE_PLAIN;
                        count_next     = '0;
                        hi_nib_next    = '0;
                        hi_inv_next    = 1'b0;
                    end
                    else
                    begin
                        hi_nib_next = item.nibble;
                        hi_inv_next = !item.hex_ok;
                        mode_next   = MODE_HI;
                    end
                end
                MODE_HI:
                begin
                    res_valid   = 1'b1;
                    hi_nib_next = '0;
                    hi_inv_next = 1'b0;
                    if (item.is_end)
                    begin
                        res_new.status = ST_TRUNC;
                        mode_next      = MODE_PLAIN;
                        count_next     = '0;
                    end
                    else if (hi_inv_reg || !item.hex_ok)
                    begin
                        res_new.status = ST_BADHEX;
                        mode_next      = MODE_DROP;
                    end
                    else if (dec_byte == 8'h00)
                    begin
                        res_new.status = ST_ZERO;
                        mode_next      = MODE_DROP;
                    end
                    else
                    begin
                        res_new.kind   = KIND_DATA;
                        res_new.data   = dec_byte;
                        res_new.length = count_reg + LEN_W'(1);
                        count_next     = count_reg + LEN_W'(1);
                        mode_next      = MODE_PLAIN;
                    end
                end
                default:
                begin
                    mode_next = MODE_PLAIN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PLAIN;
            hi_nib_reg <= '0;
            hi_inv_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            hi_nib_reg <= hi_nib_next;
            hi_inv_reg <= hi_inv_next;
            count_reg  <= count_next;
        end
    end

    upd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res_new),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res),
        .empty   (empty)
    );

endmodule
